// File: rtl/core/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache filter.
// No dependencies; the interfaces, the core and the bench refer to it by scoped names.
package salc_pkg;

    localparam int ADDR_W = 32;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_LOOKUP
    } t_state;

endpackage

// File: rtl/core/salc_if.sv
// Valid/ready request interfaces of the cache filter: address in, hit/miss out.
// Depends on salc_pkg for the address width.
interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface salc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [salc_pkg::ADDR_W-1:0] miss_line_address;

    modport source (output valid, output hit, output miss_line_address, input ready);
    modport sink (input valid, input hit, input miss_line_address, output ready);
endinterface

// File: rtl/core/salc_set_idx.sv
// Set index unit: line number modulo the set count.
// A power-of-two set count is a mask; otherwise a reciprocal multiplication with one
// correction step, with the product and then the estimated remainder registered.
module salc_set_idx #(
    parameter int LINE_W = 26,
    parameter int NSETS  = 128,
    parameter int SET_W  = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LINE_W-1:0] i_line,
    output logic              o_done,
    output logic [SET_W-1:0]  o_set
);

    localparam bit POW2 = ((NSETS & (NSETS - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            assign o_done = i_start;
            assign o_set  = (NSETS == 1) ? '0 : i_line[SET_W-1:0];
        end else begin : g_recip
            // The estimated quotient is the true one or one less, so a single
            // conditional subtraction gives the remainder.
            localparam longint unsigned RECIP = (64'd1 << LINE_W) / NSETS;

            logic                r_v1;
            logic                r_v2;
            logic [LINE_W-1:0]   r_x;
            logic [2*LINE_W-1:0] r_prod;
            logic [LINE_W-1:0]   r_est;
            logic [LINE_W-1:0]   w_q;
            logic [LINE_W-1:0]   w_qn;
            logic [LINE_W-1:0]   w_fix;

            assign w_q   = r_prod[2*LINE_W-1:LINE_W];
            assign w_qn  = w_q * LINE_W'(NSETS);
            assign w_fix = (r_est >= LINE_W'(NSETS)) ? (r_est - LINE_W'(NSETS)) : r_est;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1 <= 1'b0;
                    r_v2 <= 1'b0;
                end else begin
                    r_v1 <= i_start;
                    r_v2 <= r_v1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_x    <= i_line;
                    r_prod <= (2*LINE_W)'(i_line) * (2*LINE_W)'(RECIP);
                end
                if (r_v1) begin
                    r_est <= r_x - w_qn;
                end
            end

            assign o_done = r_v2;
            assign o_set  = w_fix[SET_W-1:0];
        end
    endgenerate

endmodule

// File: rtl/core/salc_tag_mem.sv
// Tag store: one row per set holding every way, synchronous write and
// registered read. No dependencies.
module salc_tag_mem #(
    parameter int ROW_W  = 108,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ROW_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ROW_W-1:0]  o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/salc_lru_row.sv
// Compare and LRU update of one set row, most recent way first.
// No dependencies; each entry is a valid bit above the line number.
module salc_lru_row #(
    parameter int WAYS  = 4,
    parameter int ENT_W = 27
) (
    input  logic [WAYS-1:0][ENT_W-1:0] i_row,
    input  logic [ENT_W-2:0]           i_line,
    output logic                       o_hit,
    output logic [WAYS-1:0][ENT_W-1:0] o_row
);

    logic [WAYS-1:0] w_stop;
    logic [WAYS-1:0] w_before;
    logic [WAYS-1:0] w_found;

    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            w_stop[k] = !i_row[k][ENT_W-1] || (i_row[k][ENT_W-2:0] == i_line);
        end
        for (int j = 0; j < WAYS; j++) begin
            w_before[j] = 1'b0;
            for (int k = 0; k < j; k++) begin
                w_before[j] = w_before[j] | w_stop[k];
            end
        end
        for (int k = 0; k < WAYS; k++) begin
            w_found[k] = i_row[k][ENT_W-1] && (i_row[k][ENT_W-2:0] == i_line)
                         && !w_before[k];
        end
        o_hit    = |w_found;
        o_row[0] = {1'b1, i_line};
        for (int j = 1; j < WAYS; j++) begin
            o_row[j] = w_before[j] ? i_row[j] : i_row[j-1];
        end
    end

endmodule

// File: rtl/core/set_assoc_lru_cache_filter_core.sv
// An item is one byte address; each gives one result: a hit flag and, on a miss, the line
// address. LINE_BYTES must be a power of two. After reset the tag store is cleared one set
// per cycle over all of its sets (128 at the default sizes), and no request is taken
// meanwhile. An item then goes through two steps: the set row is read from the tag memory,
// then compared, reordered and written back. When the set count is not a power of two, the
// set index comes from a reciprocal multiplication with one correction step, and the core
// waits in S_INDEX until it is done. A finished result waits in the output register while
// the next request is taken; that request's write-back waits until the register is free.
module set_assoc_lru_cache_filter_core #(
    parameter int LINE_BYTES  = 64,
    parameter int CACHE_BYTES = 32768,
    parameter int WAYS        = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    salc_req_if.sink   i_req,
    salc_rsp_if.source o_rsp
);

    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int LINE_W    = salc_pkg::ADDR_W - OFF_W;
    localparam int ENT_W     = LINE_W + 1;
    localparam int ROW_W     = WAYS * ENT_W;
    localparam int NSETS_RAW = CACHE_BYTES / (LINE_BYTES * WAYS);
    localparam int NSETS     = (NSETS_RAW > 0) ? NSETS_RAW : 1;
    localparam int SET_W     = (NSETS > 1) ? $clog2(NSETS) : 1;

    salc_pkg::t_state r_state;
    salc_pkg::t_state n_state;

    logic [SET_W-1:0]             r_clr_idx;
    logic [SET_W-1:0]             r_set;
    logic [LINE_W-1:0]            r_line;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic                         r_out_hit;
    logic [salc_pkg::ADDR_W-1:0]  r_out_addr;

    logic                         w_accept;
    logic                         w_idx_done;
    logic [SET_W-1:0]             w_idx_set;
    logic                         w_mem_we;
    logic [SET_W-1:0]             w_mem_waddr;
    logic [ROW_W-1:0]             w_mem_wdata;
    logic                         w_mem_re;
    logic                         w_load;
    logic                         w_hit;
    logic [WAYS-1:0][ENT_W-1:0]   w_rd_row;
    logic [WAYS-1:0][ENT_W-1:0]   w_new_row;
    logic [WAYS-1:0]              w_old_vld;
    logic [WAYS-1:0]              w_new_vld;

    assign i_req.ready = (r_state == salc_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_mem_re    = w_idx_done;

    salc_set_idx #(
        .LINE_W (LINE_W),
        .NSETS  (NSETS),
        .SET_W  (SET_W)
    ) u_set_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_line  (i_req.address[salc_pkg::ADDR_W-1:OFF_W]),
        .o_done  (w_idx_done),
        .o_set   (w_idx_set)
    );

    salc_tag_mem #(
        .ROW_W  (ROW_W),
        .DEPTH  (NSETS),
        .ADDR_W (SET_W)
    ) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_idx_set),
        .o_rdata (w_rd_row)
    );

    salc_lru_row #(
        .WAYS  (WAYS),
        .ENT_W (ENT_W)
    ) u_lru_row (
        .i_row  (w_rd_row),
        .i_line (r_line),
        .o_hit  (w_hit),
        .o_row  (w_new_row)
    );

    always_comb begin
        n_state     = r_state;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_set;
        w_mem_wdata = w_new_row;
        w_load      = 1'b0;
        unique case (r_state)
            salc_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_idx;
                w_mem_wdata = '0;
                if (r_clr_idx == SET_W'(NSETS - 1)) begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            salc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_idx_done ? salc_pkg::S_LOOKUP : salc_pkg::S_INDEX;
                end
            end
            salc_pkg::S_INDEX: begin
                if (w_idx_done) begin
                    n_state = salc_pkg::S_LOOKUP;
                end
            end
            salc_pkg::S_LOOKUP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_mem_we = 1'b1;
                    w_load   = 1'b1;
                    n_state  = salc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = salc_pkg::S_IDLE;
            end
        endcase
        n_out_valid = w_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= salc_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == salc_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line <= i_req.address[salc_pkg::ADDR_W-1:OFF_W];
        end
        if (w_idx_done) begin
            r_set <= w_idx_set;
        end
        if (w_load) begin
            r_out_hit  <= w_hit;
            r_out_addr <= w_hit ? '0 : {r_line, {OFF_W{1'b0}}};
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.hit               = r_out_hit;
    assign o_rsp.miss_line_address = r_out_addr;

    generate
        for (genvar k = 0; k < WAYS; k++) begin : g_vld
            assign w_old_vld[k] = w_rd_row[k][ENT_W-1];
            assign w_new_vld[k] = w_new_row[k][ENT_W-1];
        end
    endgenerate

    // The compare stage must only ever see a row that was read for the current request.
    a_row_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == salc_pkg::S_LOOKUP) |->
            ($past(w_mem_re) || ($past(r_state) == salc_pkg::S_LOOKUP)))
        else $error("lookup without a preceding tag read");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == salc_pkg::S_LOOKUP) && w_hit) |->
            ($countones(w_new_vld) == $countones(w_old_vld)))
        else $error("hit changed the number of valid ways");

    a_miss_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == salc_pkg::S_LOOKUP) && !w_hit && !(&w_old_vld)) |->
            ($countones(w_new_vld) == ($countones(w_old_vld) + 1)))
        else $error("miss into a set with a free way did not fill it");

endmodule

// File: bench/tb.sv
// Self-checking bench for the set-associative LRU cache filter: one address request in,
// one hit/miss result out. It depends on salc_pkg, the request interfaces and the core.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = salc_pkg::ADDR_W;
    localparam int LINE_BYTES  = 64;
    localparam int CACHE_BYTES = 32768;
    localparam int WAYS        = 4;
    localparam int SETS_RAW    = CACHE_BYTES / (LINE_BYTES * WAYS);
    localparam int N_SETS      = (SETS_RAW > 0) ? SETS_RAW : 1;
    localparam int OFFSET_W    = $clog2(LINE_BYTES);
    localparam int LINE_W      = ADDR_W - OFFSET_W;
    localparam int SET_W       = $clog2(N_SETS);
    localparam int TAG_W       = LINE_W - SET_W;
    localparam int POOL_TAGS   = WAYS + 2;
    localparam int HOT_SETS    = 4;
    localparam int PHASE_ITEMS = 350;
    localparam int N_PHASES    = 5;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] miss_line_address;
    } t_outcome;

    class cache_scoreboard;
        bit [LINE_W-1:0] line_tags [N_SETS][WAYS];
        bit              line_live [N_SETS][WAYS];
        t_outcome        expected_q[$];
        int              fails;

        function void note_request(logic [ADDR_W-1:0] addr);
            bit [LINE_W-1:0] line;
            int unsigned     set_idx;
            int              stop;
            bit              found;
            t_outcome        res;
            line    = addr[ADDR_W-1:OFFSET_W];
            set_idx = line % N_SETS;
            found   = 1'b0;
            stop    = WAYS;
            for (int w = 0; w < WAYS; w++) begin
                if (stop == WAYS) begin
                    if (!line_live[set_idx][w]) begin
                        stop = w;
                    end else if (line_tags[set_idx][w] == line) begin
                        found = 1'b1;
                        stop  = w;
                    end
                end
            end
            if (stop == WAYS) begin
                stop = WAYS - 1;
            end
            for (int j = stop; j > 0; j--) begin
                line_tags[set_idx][j] = line_tags[set_idx][j-1];
                line_live[set_idx][j] = line_live[set_idx][j-1];
            end
            line_tags[set_idx][0] = line;
            line_live[set_idx][0] = 1'b1;
            res.hit               = found;
            res.miss_line_address = found ? '0 : {line, {OFFSET_W{1'b0}}};
            expected_q = {expected_q, res};
        endfunction

        function void check_response(logic hit, logic [ADDR_W-1:0] miss_line_address);
            t_outcome exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, hit %0b miss_line_address %h",
                         $time, hit, miss_line_address);
                fails++;
            end else begin
                exp_res = expected_q.pop_front();
                if (hit !== exp_res.hit) begin
                    $display("%0t: hit expected %0b, actual %0b", $time, exp_res.hit, hit);
                    fails++;
                end
                if (miss_line_address !== exp_res.miss_line_address) begin
                    $display("%0t: miss_line_address expected %h, actual %h", $time,
                             exp_res.miss_line_address, miss_line_address);
                    fails++;
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    salc_req_if req_if ();
    salc_rsp_if rsp_if ();

    set_assoc_lru_cache_filter_core #(
        .LINE_BYTES  (LINE_BYTES),
        .CACHE_BYTES (CACHE_BYTES),
        .WAYS        (WAYS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    cache_scoreboard sb = new();

    bit          tx_no_idle;
    bit          rx_no_stall;
    bit          rx_hold_req;
    int unsigned stall_cycles;

    bit [TAG_W-1:0] tag_pool [POOL_TAGS];
    bit [SET_W-1:0] set_pool [HOT_SETS];

    logic [ADDR_W-1:0] corner_addrs [17] = '{
        32'h0000_0000, 32'h0000_003F, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
        32'h0000_2000, 32'h0000_4000, 32'h0000_6000, 32'h0000_0004,
        32'h0000_8010, 32'h0000_2000, 32'h0000_4020, 32'h0000_2000,
        32'h0000_2001, 32'h0000_8000, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h8000_0000
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 9) < 2) return $urandom();
        return {tag_pool[$urandom_range(0, POOL_TAGS-1)], set_pool[$urandom_range(0, HOT_SETS-1)],
                OFFSET_W'($urandom())};
    endfunction

    task automatic send_request(input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = tx_no_idle ? 0 : idle_len();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.address <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic refresh_pools();
        foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom());
        foreach (set_pool[k]) set_pool[k] = SET_W'($urandom());
    endtask

    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_no_stall) begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                if (idle_len() != 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (idle_len() + 1) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.address);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_response(rsp_if.hit, rsp_if.miss_line_address);
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid   = 1'b0;
        req_if.address = '0;
        i_rst_n        = 1'b0;
        tx_no_idle     = 1'b0;
        rx_no_stall    = 1'b0;
        rx_hold_req    = 1'b0;
        stall_cycles   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner addresses, then a set filled, hit in every way, evicted and refilled.
        foreach (corner_addrs[k]) send_request(corner_addrs[k]);
        drain_results();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            refresh_pools();
            tx_no_idle  = (phase < 2);
            rx_no_stall = (phase == 0);
            rx_hold_req = (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_address());
            end
            drain_results();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
